### design/bpww_pkg.sv
// Shared types, constants and helpers for the bit packer word writer.
package bpww_pkg;

    localparam int WORD_W = 32;
    localparam int CNT_W  = 6;
    localparam int BYTE_W = 8;

    localparam logic [CNT_W-1:0] WORD_BITS  = 6'd32;
    localparam logic             KIND_WRITE = 1'b0;
    localparam logic             KIND_FLUSH = 1'b1;

    typedef struct packed {
        logic              kind;
        logic [CNT_W-1:0]  count;
        logic [WORD_W-1:0] value;
    } cmd_t;

    typedef struct packed {
        logic [BYTE_W-1:0] out_byte;
        logic              last;
    } emit_t;

    typedef struct packed {
        logic full;
        logic empty;
    } fifo_stat_t;

    function automatic logic [WORD_W-1:0] low_mask(input logic [CNT_W-1:0] n);
        logic [2*WORD_W-1:0] m;
        begin
            m = (64'd1 << n) - 64'd1;
            if (n >= WORD_BITS)
            begin
                low_mask = '1;
            end
            else
            begin
                low_mask = m[WORD_W-1:0];
            end
        end
    endfunction

endpackage

### design/bit_packer_word_writer.sv
// Bit packer word writer: LSB-first packing into 32-bit words, sent as bytes.
// One item is accepted per cycle while the two-word queue has room. A write
// that overflows the word, or any flush, queues the word; the byte output
// sends it most significant byte first, last set on the fourth byte, and
// items are still taken meanwhile if the queue has room. A word filled
// exactly is queued by the next write that adds bits or by a flush.
// A flush always sends four bytes and clears the word.
module bit_packer_word_writer (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             cmd_valid,
    output logic             cmd_stall,
    input  bpww_pkg::cmd_t   cmd,
    output logic             emit_valid,
    input  logic             emit_stall,
    output bpww_pkg::emit_t  emit
);

    bpww_pkg::fifo_stat_t        stat;
    logic                        push, pop;
    logic [bpww_pkg::WORD_W-1:0] push_word, pop_word;

    bpww_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd_stall (cmd_stall),
        .cmd       (cmd),
        .stat      (stat),
        .push      (push),
        .push_word (push_word)
    );

    bpww_fifo u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_word (push_word),
        .pop       (pop),
        .pop_word  (pop_word),
        .stat      (stat)
    );

    bpww_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .stat       (stat),
        .pop_word   (pop_word),
        .pop        (pop),
        .emit_valid (emit_valid),
        .emit_stall (emit_stall),
        .emit       (emit)
    );

endmodule

### design/bpww_front.sv
// Front end: accepts items, packs bits into the word, hands full or flushed words on.
module bpww_front (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cmd_valid,
    output logic                          cmd_stall,
    input  bpww_pkg::cmd_t                cmd,
    input  bpww_pkg::fifo_stat_t          stat,
    output logic                          push,
    output logic [bpww_pkg::WORD_W-1:0]   push_word
);

    logic [bpww_pkg::WORD_W-1:0] accum_reg, accum_next;
    logic [bpww_pkg::CNT_W-1:0]  fill_reg, fill_next;
    logic [bpww_pkg::CNT_W-1:0]  cnt_sat, room, rem_cnt;
    logic [2*bpww_pkg::WORD_W-1:0] spill_shift, part_shift;
    logic [bpww_pkg::WORD_W-1:0] rem_val;
    logic                        accept;

    assign cmd_stall = stat.full;
    assign accept    = cmd_valid && !stat.full;

    always_comb
    begin
        cnt_sat     = (cmd.count > bpww_pkg::WORD_BITS) ? bpww_pkg::WORD_BITS : cmd.count;
        room        = bpww_pkg::WORD_BITS - fill_reg;
        rem_cnt     = cnt_sat - room;
        rem_val     = cmd.value >> room;
        spill_shift = {{bpww_pkg::WORD_W{1'b0}}, cmd.value} << fill_reg;
        part_shift  = {{bpww_pkg::WORD_W{1'b0}}, cmd.value & bpww_pkg::low_mask(cnt_sat)}
                      << fill_reg;
        accum_next  = accum_reg;
        fill_next   = fill_reg;
        push        = 1'b0;
        push_word   = accum_reg;
        if (accept)
        begin
            if (cmd.kind == bpww_pkg::KIND_FLUSH)
            begin
                push       = 1'b1;
                push_word  = accum_reg;
                accum_next = '0;
                fill_next  = '0;
            end
            else if (cnt_sat > room)
            begin
                push       = 1'b1;
                push_word  = accum_reg | spill_shift[bpww_pkg::WORD_W-1:0];
                accum_next = rem_val & bpww_pkg::low_mask(rem_cnt);
                fill_next  = rem_cnt;
            end
            else if (cnt_sat != '0)
            begin
                accum_next = accum_reg | part_shift[bpww_pkg::WORD_W-1:0];
                fill_next  = fill_reg + cnt_sat;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            accum_reg <= '0;
            fill_reg  <= '0;
        end
        else
        begin
            accum_reg <= accum_next;
            fill_reg  <= fill_next;
        end
    end

    a_fill_range: assert property (@(posedge clk) disable iff (!rst_n)
        fill_reg <= bpww_pkg::WORD_BITS)
        else $error("fill position beyond word");

    a_push_flush: assert property (@(posedge clk) disable iff (!rst_n)
        accept && cmd.kind == bpww_pkg::KIND_FLUSH |=> fill_reg == '0 && accum_reg == '0)
        else $error("flush did not clear word");

    a_push_accept: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> accept)
        else $error("word pushed without accepted item");

endmodule

### design/bpww_fifo.sv
// Two-entry word queue between front and back.
module bpww_fifo (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        push,
    input  logic [bpww_pkg::WORD_W-1:0] push_word,
    input  logic                        pop,
    output logic [bpww_pkg::WORD_W-1:0] pop_word,
    output bpww_pkg::fifo_stat_t        stat
);

    logic [bpww_pkg::WORD_W-1:0] mem [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] cnt_reg, cnt_next;

    assign stat.full  = (cnt_reg == 2'd2);
    assign stat.empty = (cnt_reg == 2'd0);
    assign pop_word   = mem[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? ~rd_ptr_reg : rd_ptr_reg;
        cnt_next    = cnt_reg + {1'b0, push} - {1'b0, pop};
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wr_ptr_reg] <= push_word;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> !stat.full)
        else $error("push into full queue");

    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> !stat.empty)
        else $error("pop from empty queue");

    a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= 2'd2)
        else $error("queue count out of range");

endmodule

### design/bpww_back.sv
// Back end: sends each queued word as four bytes, high byte first.
module bpww_back (
    input  logic                        clk,
    input  logic                        rst_n,
    input  bpww_pkg::fifo_stat_t        stat,
    input  logic [bpww_pkg::WORD_W-1:0] pop_word,
    output logic                        pop,
    output logic                        emit_valid,
    input  logic                        emit_stall,
    output bpww_pkg::emit_t             emit
);

    logic [bpww_pkg::WORD_W-1:0] word_reg, word_next;
    logic [1:0]                  idx_reg, idx_next;
    logic                        valid_reg, valid_next;
    logic                        taken;

    assign taken      = valid_reg && !emit_stall;
    assign emit_valid = valid_reg;
    assign emit.out_byte = word_reg[bpww_pkg::WORD_W-1 -: bpww_pkg::BYTE_W];
    assign emit.last     = (idx_reg == 2'd3);

    always_comb
    begin
        pop        = !stat.empty && (!valid_reg || (taken && idx_reg == 2'd3));
        word_next  = word_reg;
        idx_next   = idx_reg;
        valid_next = valid_reg;
        if (pop)
        begin
            word_next  = pop_word;
            idx_next   = 2'd0;
            valid_next = 1'b1;
        end
        else if (taken)
        begin
            if (idx_reg == 2'd3)
            begin
                valid_next = 1'b0;
            end
            else
            begin
                word_next = word_reg << bpww_pkg::BYTE_W;
                idx_next  = idx_reg + 2'd1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            idx_reg   <= 2'd0;
        end
        else
        begin
            valid_reg <= valid_next;
            idx_reg   <= idx_next;
        end
    end

    always_ff @(posedge clk)
    begin
        word_reg <= word_next;
    end

    a_drop_after_last: assert property (@(posedge clk) disable iff (!rst_n)
        $fell(valid_reg) |-> $past(taken && idx_reg == 2'd3))
        else $error("byte stream dropped mid word");

    a_load_starts_word: assert property (@(posedge clk) disable iff (!rst_n)
        pop |=> valid_reg && idx_reg == 2'd0)
        else $error("loaded word does not start at first byte");

endmodule

### verif/tb.sv
// Self-checking testbench for the bit packer word writer: directed and random items.
module tb;

    localparam int QUIET_LIMIT  = 3000;
    localparam int RANDOM_ITEMS = 20;
    localparam int HOLD_CYCLES  = 20;

    logic              clk        = 1'b0;
    logic              rst_n      = 1'b0;
    logic              cmd_valid  = 1'b0;
    logic              cmd_stall;
    bpww_pkg::cmd_t    cmd        = '0;
    logic              emit_valid;
    logic              emit_stall = 1'b0;
    bpww_pkg::emit_t   emit;

    bpww_pkg::cmd_t                pending_cmds[$];
    bpww_pkg::emit_t               expected_bytes[$];
    logic [bpww_pkg::WORD_W-1:0]   pack_word = '0;
    int                            pack_fill = 0;
    int                            send_idle_pct = 0;
    int                            recv_stall_pct = 0;
    int                            items_queued = 0;
    int                            items_accepted = 0;
    int                            flushes_accepted = 0;
    int                            bytes_checked = 0;
    int                            error_count = 0;
    int                            quiet_cycles = 0;
    logic                          cmd_taken = 1'b0;

    bit_packer_word_writer dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd_valid  (cmd_valid),
        .cmd_stall  (cmd_stall),
        .cmd        (cmd),
        .emit_valid (emit_valid),
        .emit_stall (emit_stall),
        .emit       (emit)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    function automatic bpww_pkg::cmd_t make_cmd(input logic kind,
                                                input logic [bpww_pkg::CNT_W-1:0] count,
                                                input logic [bpww_pkg::WORD_W-1:0] value);
        bpww_pkg::cmd_t c;
        c.kind  = kind;
        c.count = count;
        c.value = value;
        return c;
    endfunction

    function automatic void send_word();
        expected_bytes.push_back(bpww_pkg::emit_t'{out_byte: pack_word[31:24], last: 1'b0});
        expected_bytes.push_back(bpww_pkg::emit_t'{out_byte: pack_word[23:16], last: 1'b0});
        expected_bytes.push_back(bpww_pkg::emit_t'{out_byte: pack_word[15:8],  last: 1'b0});
        expected_bytes.push_back(bpww_pkg::emit_t'{out_byte: pack_word[7:0],   last: 1'b1});
        pack_word = '0;
        pack_fill = 0;
    endfunction

    function automatic void pack_item(input bpww_pkg::cmd_t c);
        int                          bits;
        int                          room;
        logic [bpww_pkg::WORD_W-1:0] data;
        bits = (c.count > bpww_pkg::WORD_BITS) ? bpww_pkg::WORD_W : int'(c.count);
        data = c.value;
        if (c.kind == bpww_pkg::KIND_FLUSH)
        begin
            send_word();
        end
        else
        begin
            room = bpww_pkg::WORD_W - pack_fill;
            if (bits > room)
            begin
                if (pack_fill < bpww_pkg::WORD_W)
                begin
                    pack_word |= data << pack_fill;
                end
                send_word();
                bits -= room;
                data = (room < bpww_pkg::WORD_W) ? (data >> room) : '0;
            end
            if (bits > 0)
            begin
                if (bits < bpww_pkg::WORD_W)
                begin
                    data &= (32'd1 << bits) - 32'd1;
                end
                pack_word |= data << pack_fill;
                pack_fill += bits;
            end
        end
    endfunction

    function automatic void queue_item(input bpww_pkg::cmd_t c);
        pending_cmds.push_back(c);
        items_queued++;
    endfunction

    // drive inputs at the falling edge; hold an item until it is taken
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            emit_stall <= ($urandom_range(0, 99) < recv_stall_pct);
            if (!cmd_valid || cmd_taken)
            begin
                if (pending_cmds.size() != 0 && $urandom_range(0, 99) >= send_idle_pct)
                begin
                    cmd       <= pending_cmds.pop_front();
                    cmd_valid <= 1'b1;
                end
                else
                begin
                    cmd_valid <= 1'b0;
                end
            end
        end
    end

    always @(posedge clk)
    begin : monitor
        bpww_pkg::emit_t want;
        cmd_taken <= rst_n && cmd_valid && !cmd_stall;
        if (rst_n)
        begin
            if (emit_valid && !emit_stall)
            begin
                if (expected_bytes.size() == 0)
                begin
                    $error("out_byte: no byte expected, got %02h", emit.out_byte);
                    error_count++;
                end
                else
                begin
                    want = expected_bytes.pop_front();
                    if (emit.out_byte !== want.out_byte)
                    begin
                        $error("out_byte: expected %02h, got %02h", want.out_byte,
                               emit.out_byte);
                        error_count++;
                    end
                    if (emit.last !== want.last)
                    begin
                        $error("last: expected %b, got %b", want.last, emit.last);
                        error_count++;
                    end
                    bytes_checked++;
                end
            end
            if (cmd_valid && !cmd_stall)
            begin
                pack_item(cmd);
                items_accepted++;
                if (cmd.kind == bpww_pkg::KIND_FLUSH)
                begin
                    flushes_accepted++;
                end
            end
            if ((emit_valid && !emit_stall) || (cmd_valid && !cmd_stall))
            begin
                quiet_cycles = 0;
            end
            else if (pending_cmds.size() != 0 || expected_bytes.size() != 0 || cmd_valid)
            begin
                quiet_cycles++;
            end
            if (quiet_cycles >= QUIET_LIMIT)
            begin
                $display("watchdog: no item moved for %0d cycles", QUIET_LIMIT);
                $display("status: fail");
                $finish;
            end
        end
    end

    task automatic wait_drained();
        do
        begin
            @(negedge clk);
        end
        while (items_accepted != items_queued || expected_bytes.size() != 0);
    endtask

    task automatic run_phase(input int send_pct, input int recv_pct);
        int             i;
        int             pick;
        bpww_pkg::cmd_t c;
        @(posedge clk);
        send_idle_pct  = send_pct;
        recv_stall_pct = recv_pct;
        for (i = 0; i < RANDOM_ITEMS; i++)
        begin
            c.value = $urandom();
            c.count = 6'($urandom_range(0, 63));
            c.kind  = bpww_pkg::KIND_WRITE;
            pick    = int'($urandom_range(0, 99));
            if (pick < 12)
            begin
                c.kind = bpww_pkg::KIND_FLUSH;
            end
            else if (pick < 17)
            begin
                c.count = '0;
            end
            else if (pick < 29)
            begin
                c.count = bpww_pkg::WORD_BITS;
            end
            else if (pick >= 34)
            begin
                c.count = 6'($urandom_range(1, 31));
            end
            queue_item(c);
        end
        wait_drained();
    endtask

    initial
    begin
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        queue_item(make_cmd(bpww_pkg::KIND_FLUSH, 6'd0,  32'h0000_0000));
        queue_item(make_cmd(bpww_pkg::KIND_WRITE, 6'd0,  32'hFFFF_FFFF));
        queue_item(make_cmd(bpww_pkg::KIND_WRITE, 6'd32, 32'hDEAD_BEEF));
        queue_item(make_cmd(bpww_pkg::KIND_WRITE, 6'd0,  32'hFFFF_FFFF));
        queue_item(make_cmd(bpww_pkg::KIND_WRITE, 6'd1,  32'h0000_0001));
        queue_item(make_cmd(bpww_pkg::KIND_WRITE, 6'd31, 32'h7FFF_FFFF));
        queue_item(make_cmd(bpww_pkg::KIND_FLUSH, 6'd63, 32'hFFFF_FFFF));
        queue_item(make_cmd(bpww_pkg::KIND_WRITE, 6'd5,  32'hFFFF_FFFF));
        queue_item(make_cmd(bpww_pkg::KIND_WRITE, 6'd30, 32'hAAAA_AAAA));
        queue_item(make_cmd(bpww_pkg::KIND_WRITE, 6'd63, 32'h1234_5678));
        queue_item(make_cmd(bpww_pkg::KIND_WRITE, 6'd33, 32'h0000_0000));
        queue_item(make_cmd(bpww_pkg::KIND_WRITE, 6'd32, 32'hFFFF_FFFF));
        queue_item(make_cmd(bpww_pkg::KIND_WRITE, 6'd32, 32'h0000_0000));
        queue_item(make_cmd(bpww_pkg::KIND_FLUSH, 6'd0,  32'h0000_0000));
        queue_item(make_cmd(bpww_pkg::KIND_FLUSH, 6'd0,  32'h5555_5555));
        queue_item(make_cmd(bpww_pkg::KIND_WRITE, 6'd40, 32'hFFFF_FFFF));
        queue_item(make_cmd(bpww_pkg::KIND_WRITE, 6'd16, 32'h5A5A_ABCD));
        queue_item(make_cmd(bpww_pkg::KIND_WRITE, 6'd16, 32'h0000_1234));
        queue_item(make_cmd(bpww_pkg::KIND_WRITE, 6'd7,  32'h0000_0055));
        queue_item(make_cmd(bpww_pkg::KIND_FLUSH, 6'd32, 32'h0000_0000));
        wait_drained();
        run_phase(0, 0);
        run_phase(86, 0);
        run_phase(0, 86);
        run_phase(29, 29);
        run_phase(0, 0);
        repeat (HOLD_CYCLES) @(negedge clk);
        $display("covered %0d items (%0d flushes) and checked %0d emitted bytes",
                 items_accepted, flushes_accepted, bytes_checked);
        $display("under no idling, sender gaps, receiver stalls and both together");
        if (error_count == 0)
        begin
            $display("status: pass");
        end
        else
        begin
            $display("status: fail");
        end
        $finish;
    end

endmodule

### files.f
design/bpww_pkg.sv
design/bpww_front.sv
design/bpww_fifo.sv
design/bpww_back.sv
design/bit_packer_word_writer.sv
verif/tb.sv
